FILE: hw/rtl/ppg_pkg.sv
// package for the grayscale point operation and gamma block
// holds widths, register indexes, payload structs and the log and root tables
// no dependencies
package ppg_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int MAXV = (1 << PIXEL_BITS) - 1;
  localparam int MIDV = (1 << (PIXEL_BITS - 1)) - 1;
  localparam int FRAC_BITS = 30;
  localparam int LW = FRAC_BITS + $clog2(PIXEL_BITS + 1);
  localparam int GAMMA_W = 12;
  localparam int OFFSET_W = 8;
  localparam int MODE_W = 3;
  localparam int EW = GAMMA_W + LW - 8;
  localparam int NW = EW - FRAC_BITS;
  localparam int YW = 32;
  localparam int LATENCY = FRAC_BITS + 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = GAMMA_W;

  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_COPY     = 3'd0,
    MODE_BRIGHTEN = 3'd1,
    MODE_DARKEN   = 3'd2,
    MODE_INVERT   = 3'd3,
    MODE_THRESH   = 3'd4,
    MODE_GAMMA    = 3'd5
  } mode_t;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  typedef struct packed {
    pix_t pixel_in;
    logic frame_end_in;
  } in_t;

  typedef struct packed {
    pix_t pixel_out;
    logic frame_end_out;
  } out_t;

  // travels alongside the gamma datapath
  typedef struct packed {
    logic use_gamma;
    logic gzero;
    logic pzero;
    pix_t simple;
    logic frame_end;
  } side_t;

  typedef logic [LW-1:0] ltab_t [1 << PIXEL_BITS];
  typedef logic [YW-1:0] ctab_t [FRAC_BITS];

  function automatic logic [63:0] isqrt64(input logic [63:0] v0);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v = v0;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] log2_q30(input logic [63:0] v);
    int n;
    logic [63:0] m;
    logic [63:0] frac;
    n = 0;
    frac = '0;
    while (n < 31 && (v >> (n + 1)) != 64'd0) n++;
    m = v << (FRAC_BITS - n);
    for (int i = 1; i <= FRAC_BITS; i++) begin
      m = (m * m) >> FRAC_BITS;
      if (m >= (64'd2 << FRAC_BITS)) begin
        m = m >> 1;
        frac = frac | (64'd1 << (FRAC_BITS - i));
      end
    end
    return (64'(n) << FRAC_BITS) | frac;
  endfunction

  function automatic ltab_t build_ltab();
    ltab_t t;
    logic [63:0] lmax;
    logic [63:0] lp;
    lmax = log2_q30(64'(MAXV));
    for (int p = 0; p < (1 << PIXEL_BITS); p++) begin
      lp = log2_q30(64'(p));
      t[p] = (lmax > lp) ? LW'(lmax - lp) : '0;
    end
    return t;
  endfunction

  function automatic ctab_t build_ctab();
    ctab_t t;
    logic [63:0] c;
    c = 64'd1 << 30;
    for (int k = 0; k < FRAC_BITS; k++) begin
      c = isqrt64(c << 31);
      t[k] = c[YW-1:0];
    end
    return t;
  endfunction

  localparam ltab_t L_TAB = build_ltab();
  localparam ctab_t C_TAB = build_ctab();

endpackage

FILE: hw/rtl/ppg_gamma.sv
// pipelined gamma datapath: log table, exponent multiply, one root factor per stage
// depends on ppg_pkg
module ppg_gamma (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  ppg_pkg::pix_t              in_pixel,
  input  logic [ppg_pkg::GAMMA_W-1:0] in_gamma,
  input  ppg_pkg::side_t             in_side,
  output logic                       out_valid,
  output ppg_pkg::out_t              out_data
);

  localparam int NS = ppg_pkg::FRAC_BITS + 1;

  logic                         v1_r;
  logic [ppg_pkg::LW-1:0]       l1_r;
  logic [ppg_pkg::GAMMA_W-1:0]  g1_r;
  ppg_pkg::side_t               s1_r;

  logic [ppg_pkg::GAMMA_W+ppg_pkg::LW-1:0] eprod;

  logic                          sv_r [NS];
  logic [ppg_pkg::YW-1:0]        sy_r [NS];
  logic [ppg_pkg::NW-1:0]        sn_r [NS];
  logic [ppg_pkg::FRAC_BITS-1:0] sf_r [NS];
  ppg_pkg::side_t                ss_r [NS];

  logic                   vsh_r;
  logic [ppg_pkg::YW-1:0] ysh_r;
  ppg_pkg::side_t         ssh_r;

  logic [ppg_pkg::YW+ppg_pkg::PIXEL_BITS-1:0] rprod;
  logic [ppg_pkg::PIXEL_BITS:0]               rval;
  ppg_pkg::pix_t                              gpix;
  ppg_pkg::pix_t                              pix_nxt;

  logic          valid_r;
  ppg_pkg::out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
    end
    l1_r <= ppg_pkg::L_TAB[in_pixel];
    g1_r <= in_gamma;
    s1_r <= in_side;
  end

  assign eprod = (ppg_pkg::GAMMA_W + ppg_pkg::LW)'(g1_r) *
                 (ppg_pkg::GAMMA_W + ppg_pkg::LW)'(l1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else begin
      sv_r[0] <= v1_r;
    end
    sy_r[0] <= ppg_pkg::YW'(64'd1 << 31);
    sn_r[0] <= eprod[ppg_pkg::GAMMA_W+ppg_pkg::LW-1:ppg_pkg::FRAC_BITS+8];
    sf_r[0] <= eprod[ppg_pkg::FRAC_BITS+7:8];
    ss_r[0] <= s1_r;
  end

  for (genvar k = 0; k < ppg_pkg::FRAC_BITS; k++) begin : g_root
    logic [2*ppg_pkg::YW-1:0] yprod;
    assign yprod = (2*ppg_pkg::YW)'(sy_r[k]) * (2*ppg_pkg::YW)'(ppg_pkg::C_TAB[k]);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[k+1] <= 1'b0;
      end else begin
        sv_r[k+1] <= sv_r[k];
      end
      sy_r[k+1] <= sf_r[k][ppg_pkg::FRAC_BITS-1-k] ? yprod[62:31] : sy_r[k];
      sn_r[k+1] <= sn_r[k];
      sf_r[k+1] <= sf_r[k];
      ss_r[k+1] <= ss_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsh_r <= 1'b0;
    end else begin
      vsh_r <= sv_r[NS-1];
    end
    ysh_r <= (sn_r[NS-1] >= ppg_pkg::NW'(32)) ? '0 : (sy_r[NS-1] >> sn_r[NS-1][4:0]);
    ssh_r <= ss_r[NS-1];
  end

  assign rprod = (ppg_pkg::YW + ppg_pkg::PIXEL_BITS)'(ysh_r) *
                 (ppg_pkg::YW + ppg_pkg::PIXEL_BITS)'(ppg_pkg::MAXV);
  assign rval = rprod[ppg_pkg::YW+ppg_pkg::PIXEL_BITS-1:31];

  always_comb begin
    if (rval > (ppg_pkg::PIXEL_BITS+1)'(ppg_pkg::MAXV)) begin
      gpix = ppg_pkg::pix_t'(ppg_pkg::MAXV);
    end else begin
      gpix = rval[ppg_pkg::PIXEL_BITS-1:0];
    end
    priority if (!ssh_r.use_gamma) begin
      pix_nxt = ssh_r.simple;
    end else if (ssh_r.gzero) begin
      pix_nxt = ppg_pkg::pix_t'(ppg_pkg::MAXV);
    end else if (ssh_r.pzero) begin
      pix_nxt = '0;
    end else begin
      pix_nxt = gpix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vsh_r;
    end
    out_r.pixel_out <= pix_nxt;
    out_r.frame_end_out <= ssh_r.frame_end;
  end

  assign out_valid = valid_r;
  assign out_data = out_r;

endmodule

FILE: hw/rtl/pixel_point_op_gamma.sv
// top level of the grayscale point operation block with gamma correction
// depends on ppg_pkg and ppg_gamma
//
//   channel   ports                              transaction
//   input     start, busy, in_data               start high and busy low at a clock edge
//   result    out_valid, out_data                one cycle strobe, always taken
//   config    cfg_we, cfg_idx, cfg_wdata         cfg_we high at a clock edge
//
// one pixel per clock; busy is always low
// every result passes through a 30 stage root factor multiply chain plus four table,
// exponent, shift and output stages after its transaction
// synchronous reset clears the pipeline valids and the config registers to their defaults
module pixel_point_op_gamma (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  ppg_pkg::in_t                  in_data,
  output logic                          out_valid,
  output ppg_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [ppg_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ppg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [ppg_pkg::MODE_W-1:0]   mode_r;
  logic [ppg_pkg::OFFSET_W-1:0] offset_r;
  logic [ppg_pkg::GAMMA_W-1:0]  gamma_r;

  ppg_pkg::pix_t              pix;
  logic [ppg_pkg::PIXEL_BITS:0] sum;
  ppg_pkg::pix_t              simple;
  ppg_pkg::side_t             side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ppg_pkg::MODE_COPY;
      offset_r <= '0;
      gamma_r <= ppg_pkg::GAMMA_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        ppg_pkg::CFG_OP_MODE: mode_r <= cfg_wdata[ppg_pkg::MODE_W-1:0];
        ppg_pkg::CFG_OFFSET:  offset_r <= cfg_wdata[ppg_pkg::OFFSET_W-1:0];
        ppg_pkg::CFG_GAMMA:   gamma_r <= cfg_wdata[ppg_pkg::GAMMA_W-1:0];
        default: ;
      endcase
    end
  end

  assign pix = in_data.pixel_in;
  assign sum = (ppg_pkg::PIXEL_BITS+1)'(pix) + (ppg_pkg::PIXEL_BITS+1)'(offset_r);

  always_comb begin
    unique case (mode_r)
      ppg_pkg::MODE_BRIGHTEN:
        simple = (sum > (ppg_pkg::PIXEL_BITS+1)'(ppg_pkg::MAXV)) ?
                 ppg_pkg::pix_t'(ppg_pkg::MAXV) : sum[ppg_pkg::PIXEL_BITS-1:0];
      ppg_pkg::MODE_DARKEN:
        simple = ((ppg_pkg::PIXEL_BITS+1)'(pix) >= (ppg_pkg::PIXEL_BITS+1)'(offset_r)) ?
                 ppg_pkg::pix_t'((ppg_pkg::PIXEL_BITS+1)'(pix) -
                                 (ppg_pkg::PIXEL_BITS+1)'(offset_r)) : '0;
      ppg_pkg::MODE_INVERT:
        simple = ppg_pkg::pix_t'(ppg_pkg::MAXV) - pix;
      ppg_pkg::MODE_THRESH:
        simple = (pix < ppg_pkg::pix_t'(ppg_pkg::MIDV)) ? '0 : ppg_pkg::pix_t'(ppg_pkg::MAXV);
      default:
        simple = pix;
    endcase
  end

  assign side.use_gamma = (mode_r == ppg_pkg::MODE_GAMMA);
  assign side.gzero = (gamma_r == '0);
  assign side.pzero = (pix == '0);
  assign side.simple = simple;
  assign side.frame_end = in_data.frame_end_in;

  ppg_gamma u_gamma (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_pixel  (pix),
    .in_gamma  (gamma_r),
    .in_side   (side),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign busy = 1'b0;

endmodule

FILE: hw/rtl/ppg_checker.sv
// port checker for pixel_point_op_gamma, attached by bind
// depends on ppg_pkg
module ppg_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input ppg_pkg::in_t  in_data,
  input logic          out_valid,
  input ppg_pkg::out_t out_data
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, ppg_pkg::LATENCY))
    else $error("result without transaction");

  a_frame_end_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.frame_end_out == $past(in_data.frame_end_in, ppg_pkg::LATENCY))
    else $error("frame end flag changed");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start, ppg_pkg::LATENCY) && $past(rst_n, ppg_pkg::LATENCY) &&
    $stable(rst_n) && $past(rst_n) |-> out_valid || !$past(rst_n, ppg_pkg::LATENCY - 1))
    else $error("transaction lost");

endmodule

bind pixel_point_op_gamma ppg_checker u_ppg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
